@@ rtl/trsmb_pkg.sv @@
`default_nettype none
package trsmb_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [30:0] q30u_t;

  localparam int NIT = 6;
  localparam int NLANE = 3;
  localparam q30u_t ONE = 31'h4000_0000;
  localparam logic [26:0] DEG_RAD = 27'd74961321;

  localparam logic [7:0] SIN_K [0:NIT-1] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_K [0:NIT-1] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

  function automatic word_t smul(input word_t a, input word_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [31:0] m;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    pr = 64'(ma) * 64'(mb) + 64'h2000_0000;
    m = pr[61:30];
    return (a[31] != b[31]) ? word_t'(-m) : word_t'(m);
  endfunction

endpackage
`default_nettype wire

@@ rtl/trs_model_matrix_builder_core.sv @@
// channel | signals                                  | handshake
// in      | pos_*, angle_*, scale_*                   | start && !busy
// out     | r0c0..r2c2, trans_x/y/z                  | done, one cycle
// One word enters per cycle; busy is held low.
// Pipeline: angle reduction, six Taylor steps of three stages each
// for sine and cosine, quadrant map, two product levels, sums, scale, clamp.
// Reset clears the valid bits only; the receiver cannot stall, so nothing holds.
`default_nettype none
module trs_model_matrix_builder_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  output logic        done,
  input  wire  [31:0] pos_x,
  input  wire  [31:0] pos_y,
  input  wire  [31:0] pos_z,
  input  wire  [31:0] angle_x,
  input  wire  [31:0] angle_y,
  input  wire  [31:0] angle_z,
  input  wire  [31:0] scale_x,
  input  wire  [31:0] scale_y,
  input  wire  [31:0] scale_z,
  output logic [31:0] r0c0,
  output logic [31:0] r0c1,
  output logic [31:0] r0c2,
  output logic [31:0] r1c0,
  output logic [31:0] r1c1,
  output logic [31:0] r1c2,
  output logic [31:0] r2c0,
  output logic [31:0] r2c1,
  output logic [31:0] r2c2,
  output logic [31:0] trans_x,
  output logic [31:0] trans_y,
  output logic [31:0] trans_z
);

  localparam int W = 32 - FRAC_BITS;
  localparam int AW = W + 1;
  localparam int QW = AW - 8;
  localparam int TW = 7 + FRAC_BITS;
  localparam int KOFS = (2 ** (W - 1) + 359) / 360;
  localparam logic [AW-1:0] OFS = AW'(360 * KOFS);
  localparam logic [31:0] RED_M = 32'((64'd1 << 40) / 64'd360);
  localparam int NST = 3 * trsmb_pkg::NIT;
  localparam int LAT = NST + 11;
  localparam int SC_AT = LAT - 2;

  logic [LAT:1] vld;
  logic [31:0] pos_d [1:LAT][0:2];
  logic [31:0] sc_d [1:SC_AT][0:2];

  logic [31:0] ang [0:2];
  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-1:1], start};
    end
  end

  always_ff @(posedge clk) begin
    pos_d[1][0] <= pos_x;
    pos_d[1][1] <= pos_y;
    pos_d[1][2] <= pos_z;
    sc_d[1][0] <= scale_x;
    sc_d[1][1] <= scale_y;
    sc_d[1][2] <= scale_z;
    for (int j = 2; j <= LAT; j++) begin
      pos_d[j] <= pos_d[j-1];
    end
    for (int j = 2; j <= SC_AT; j++) begin
      sc_d[j] <= sc_d[j-1];
    end
  end

  trsmb_pkg::word_t sn [0:2];
  trsmb_pkg::word_t cs [0:2];

  for (genvar l = 0; l < trsmb_pkg::NLANE; l++) begin : g_lane
    logic [AW-1:0] ahu1;
    logic [QW-1:0] qe1;
    logic [FRAC_BITS-1:0] lo1;
    logic [AW-1:0] ahu_c;
    logic [AW+31:0] red_pr;
    logic [AW-1:0] rem_c;
    logic [AW-1:0] rc_c;
    logic [8:0] rint_c;
    logic [1:0] quad_c;
    logic [6:0] tint_c;
    logic [1:0] q2;
    logic [TW-1:0] t2;
    logic [63:0] xs_c;
    logic [1:0] q3;
    logic [30:0] x3;
    logic [62:0] x2s_c;
    logic [30:0] xd [0:NST];
    logic [31:0] x2d [0:NST];
    logic [1:0] qd [0:NST];
    trsmb_pkg::q30u_t pp [0:1][0:trsmb_pkg::NIT];
    logic [62:0] fs_c;
    logic [62:0] fc_c;
    logic [32:0] h_c;
    trsmb_pkg::q30u_t s_f;
    trsmb_pkg::q30u_t c_f;
    logic [1:0] q_f;

    assign ahu_c = AW'({{(AW - W){ang[l][31]}}, ang[l][31:FRAC_BITS]}) + OFS;
    assign red_pr = (AW + 32)'(ahu_c) * (AW + 32)'(RED_M);

    always_ff @(posedge clk) begin
      ahu1 <= ahu_c;
      qe1 <= red_pr[AW+31:40];
      lo1 <= ang[l][FRAC_BITS-1:0];
    end

    always_comb begin
      rem_c = ahu1 - AW'((AW + 9)'(qe1) * (AW + 9)'(360));
      rc_c = (rem_c >= AW'(360)) ? rem_c - AW'(360) : rem_c;
      rint_c = 9'(rc_c);
      if (rint_c >= 9'd270) begin
        quad_c = 2'd3;
      end else if (rint_c >= 9'd180) begin
        quad_c = 2'd2;
      end else if (rint_c >= 9'd90) begin
        quad_c = 2'd1;
      end else begin
        quad_c = 2'd0;
      end
      tint_c = 7'(rint_c - 9'(quad_c) * 9'd90);
    end

    always_ff @(posedge clk) begin
      q2 <= quad_c;
      t2 <= {tint_c, lo1};
    end

    assign xs_c = 64'(t2) * 64'(trsmb_pkg::DEG_RAD) + (64'd1 << (FRAC_BITS + 1));

    always_ff @(posedge clk) begin
      q3 <= q2;
      x3 <= xs_c[FRAC_BITS+32:FRAC_BITS+2];
    end

    assign x2s_c = 63'(x3) * 63'(x3) + 63'h2000_0000;

    always_ff @(posedge clk) begin
      xd[0] <= x3;
      x2d[0] <= x2s_c[61:30];
      qd[0] <= q3;
      for (int j = 1; j <= NST; j++) begin
        xd[j] <= xd[j-1];
        x2d[j] <= x2d[j-1];
        qd[j] <= qd[j-1];
      end
    end

    for (genvar f = 0; f < 2; f++) begin : g_fn
      assign pp[f][0] = trsmb_pkg::ONE;
      for (genvar i = 0; i < trsmb_pkg::NIT; i++) begin : g_it
        localparam logic [7:0] K = (f == 0) ? trsmb_pkg::SIN_K[i] : trsmb_pkg::COS_K[i];
        localparam logic [31:0] M = 32'((64'd1 << 34) / 64'(K));
        logic [62:0] va_c;
        logic [32:0] ua;
        logic [32:0] ub;
        logic [64:0] qb_pr;
        logic [30:0] qb;
        logic [33:0] rem_i;
        logic [30:0] q_i;

        assign va_c = 63'(x2d[3*i]) * 63'(pp[f][i]) + 63'h2000_0000;
        assign qb_pr = 65'(ua) * 65'(M);
        assign rem_i = 34'(ub) - 34'(39'(qb) * 39'(K));
        assign q_i = qb + ((rem_i >= 34'(K)) ? 31'd1 : 31'd0);

        always_ff @(posedge clk) begin
          ua <= 33'(va_c[61:30]) + 33'(K >> 1);
          ub <= ua;
          qb <= qb_pr[64:34];
          pp[f][i+1] <= trsmb_pkg::ONE - q_i;
        end
      end
    end

    assign fs_c = 63'(xd[NST]) * 63'(pp[0][trsmb_pkg::NIT]) + 63'h2000_0000;
    assign fc_c = 63'(x2d[NST]) * 63'(pp[1][trsmb_pkg::NIT]) + 63'h2000_0000;
    assign h_c = 33'(fc_c[61:30]) + 33'd1;

    always_ff @(posedge clk) begin
      s_f <= (fs_c[61:30] > 32'(trsmb_pkg::ONE)) ? trsmb_pkg::ONE : 31'(fs_c[61:30]);
      c_f <= (h_c[32:1] < 32'(trsmb_pkg::ONE)) ?
             31'(32'(trsmb_pkg::ONE) - h_c[32:1]) : 31'd0;
      q_f <= qd[NST];
    end

    always_ff @(posedge clk) begin
      case (q_f)
        2'd0: begin
          sn[l] <= trsmb_pkg::word_t'(32'(s_f));
          cs[l] <= trsmb_pkg::word_t'(32'(c_f));
        end
        2'd1: begin
          sn[l] <= trsmb_pkg::word_t'(32'(c_f));
          cs[l] <= -trsmb_pkg::word_t'(32'(s_f));
        end
        2'd2: begin
          sn[l] <= -trsmb_pkg::word_t'(32'(s_f));
          cs[l] <= -trsmb_pkg::word_t'(32'(c_f));
        end
        default: begin
          sn[l] <= -trsmb_pkg::word_t'(32'(c_f));
          cs[l] <= trsmb_pkg::word_t'(32'(s_f));
        end
      endcase
    end
  end

  trsmb_pkg::word_t cycz, cysz, sxsy, cxsz, cxcz, sxcy, sxsz, cxsy, cxcy;
  trsmb_pkg::word_t sy1, cz1, sz1;
  trsmb_pkg::word_t sxsycz, sxsysz, cxsycz, cxsysz;
  trsmb_pkg::word_t cycz2, cysz2, cxsz2, cxcz2, sxcy2, sxsz2, cxcy2, sy2, sxcz2, sxcz;
  logic signed [33:0] me [0:8];
  logic [33:0] smag [0:8];
  logic sneg [0:8];
  logic [31:0] res [0:8];

  always_ff @(posedge clk) begin
    cycz <= trsmb_pkg::smul(cs[1], cs[2]);
    cysz <= trsmb_pkg::smul(cs[1], sn[2]);
    sxsy <= trsmb_pkg::smul(sn[0], sn[1]);
    cxsz <= trsmb_pkg::smul(cs[0], sn[2]);
    cxcz <= trsmb_pkg::smul(cs[0], cs[2]);
    sxcy <= trsmb_pkg::smul(sn[0], cs[1]);
    sxsz <= trsmb_pkg::smul(sn[0], sn[2]);
    cxsy <= trsmb_pkg::smul(cs[0], sn[1]);
    cxcy <= trsmb_pkg::smul(cs[0], cs[1]);
    sxcz <= trsmb_pkg::smul(sn[0], cs[2]);
    sy1 <= sn[1];
    cz1 <= cs[2];
    sz1 <= sn[2];
  end

  always_ff @(posedge clk) begin
    sxsycz <= trsmb_pkg::smul(sxsy, cz1);
    sxsysz <= trsmb_pkg::smul(sxsy, sz1);
    cxsycz <= trsmb_pkg::smul(cxsy, cz1);
    cxsysz <= trsmb_pkg::smul(cxsy, sz1);
    cycz2 <= cycz;
    cysz2 <= cysz;
    cxsz2 <= cxsz;
    cxcz2 <= cxcz;
    sxcy2 <= sxcy;
    sxsz2 <= sxsz;
    cxcy2 <= cxcy;
    sxcz2 <= sxcz;
    sy2 <= sy1;
  end

  always_ff @(posedge clk) begin
    me[0] <= 34'(cycz2);
    me[1] <= -34'(cysz2);
    me[2] <= 34'(sy2);
    me[3] <= 34'(sxsycz) + 34'(cxsz2);
    me[4] <= 34'(cxcz2) - 34'(sxsysz);
    me[5] <= -34'(sxcy2);
    me[6] <= 34'(sxsz2) - 34'(cxsycz);
    me[7] <= 34'(cxsysz) + 34'(sxcz2);
    me[8] <= 34'(cxcy2);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      logic [31:0] em;
      logic [31:0] scm;
      logic [31:0] scv;
      logic [63:0] pr;
      scv = sc_d[SC_AT][i % 3];
      em = me[i][33] ? 32'(-me[i]) : 32'(me[i]);
      scm = scv[31] ? 32'(-scv) : scv;
      pr = 64'(em) * 64'(scm) + 64'h2000_0000;
      smag[i] <= pr[63:30];
      sneg[i] <= me[i][33] != scv[31];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      if (sneg[i]) begin
        res[i] <= (smag[i] > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-smag[i]);
      end else begin
        res[i] <= (smag[i] > 34'h0_7fff_ffff) ? 32'h7fff_ffff : 32'(smag[i]);
      end
    end
  end

  assign done = vld[LAT];
  assign r0c0 = res[0];
  assign r0c1 = res[1];
  assign r0c2 = res[2];
  assign r1c0 = res[3];
  assign r1c1 = res[4];
  assign r1c2 = res[5];
  assign r2c0 = res[6];
  assign r2c1 = res[7];
  assign r2c2 = res[8];
  assign trans_x = pos_d[LAT][0];
  assign trans_y = pos_d[LAT][1];
  assign trans_z = pos_d[LAT][2];

endmodule
`default_nettype wire

@@ rtl/trsmb_checker.sv @@
`default_nettype none
module trsmb_checker #(
  parameter int LAT = 29
) (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [31:0] pos_x,
  input wire [31:0] scale_x,
  input wire [31:0] trans_x,
  input wire [31:0] r0c0,
  input wire [31:0] r1c0,
  input wire [31:0] r2c0
);

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT)) else $error("done without accepted word");

  a_word_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("accepted word lost");

  a_trans: assert property (@(posedge clk) disable iff (rst)
    done |-> trans_x == $past(pos_x, LAT)) else $error("translation mismatch");

  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    (done && $past(scale_x, LAT) == 32'd0) |-> (r0c0 == 32'd0 && r1c0 == 32'd0 &&
    r2c0 == 32'd0)) else $error("zero scale column not zero");

endmodule

bind trs_model_matrix_builder_core trsmb_checker #(.LAT(29)) u_trsmb_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .pos_x(pos_x),
  .scale_x(scale_x), .trans_x(trans_x), .r0c0(r0c0), .r1c0(r1c0), .r2c0(r2c0)
);
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
module tb_top;

  typedef struct {
    logic [31:0] px, py, pz, ax, ay, az, sx, sy, sz;
  } xform_in_t;

  typedef struct {
    logic [31:0] m [0:8];
    logic [31:0] tx, ty, tz;
  } matrix_out_t;

  localparam int FB = 16;
  localparam longint unsigned QONE = 64'd1 << 30;
  localparam longint unsigned DEG2RAD = 64'd74961321;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
  wire busy, done;
  wire [31:0] r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
  wire [31:0] trans_x, trans_y, trans_z;

  trs_model_matrix_builder_core dut (
    .clk, .rst, .start, .busy, .done,
    .pos_x, .pos_y, .pos_z, .angle_x, .angle_y, .angle_z,
    .scale_x, .scale_y, .scale_z,
    .r0c0, .r0c1, .r0c2, .r1c0, .r1c1, .r1c2, .r2c0, .r2c1, .r2c2,
    .trans_x, .trans_y, .trans_z
  );

  always #10 clk = ~clk;

  xform_in_t pending_words [$];
  matrix_out_t expected_matrices [$];
  int mismatches = 0;
  int issued = 0;
  bit stim_done = 1'b0;
  bit hold_for_drain = 1'b0;
  int drain_at = -1;
  int cycle = 0;
  int idle_cycles = 0;

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint signed q30_smul(longint signed a, longint signed b);
    longint unsigned ma, mb, mm;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mm = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(mm) : longint'(mm);
  endfunction

  task automatic deg_sincos(input logic [31:0] raw, output longint signed sn,
                            output longint signed cs);
    longint signed a, full, quarter, r;
    longint unsigned t, x, x2, p, s, h, c;
    int q;
    longint unsigned sk [0:5];
    longint unsigned ck [0:5];
    sk = '{156, 110, 72, 42, 20, 6};
    ck = '{182, 132, 90, 56, 30, 12};
    a = longint'($signed(raw));
    full = 64'sd360 <<< FB;
    quarter = 64'sd90 <<< FB;
    r = a % full;
    if (r < 0) r += full;
    q = int'(r / quarter);
    t = r % quarter;
    x = (t * DEG2RAD + (64'd1 << (FB + 1))) >> (FB + 2);
    x2 = q30_mul(x, x);
    p = QONE;
    for (int i = 0; i < 6; i++) p = QONE - (q30_mul(x2, p) + sk[i] / 2) / sk[i];
    s = q30_mul(x, p);
    if (s > QONE) s = QONE;
    p = QONE;
    for (int i = 0; i < 6; i++) p = QONE - (q30_mul(x2, p) + ck[i] / 2) / ck[i];
    h = (q30_mul(x2, p) + 1) >> 1;
    c = h < QONE ? QONE - h : 0;
    case (q & 3)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -longint'(s); end
      2: begin sn = -longint'(s); cs = -longint'(c); end
      default: begin sn = -longint'(c); cs = s; end
    endcase
  endtask

  function automatic logic [31:0] scale_sat(longint signed e, logic [31:0] sc);
    longint signed v;
    v = q30_smul(e, longint'($signed(sc)));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_matrix(input xform_in_t w, output matrix_out_t o);
    longint signed sx, cx, sy, cy, sz, cz;
    longint signed e [0:8];
    logic [31:0] scl [0:2];
    deg_sincos(w.ax, sx, cx);
    deg_sincos(w.ay, sy, cy);
    deg_sincos(w.az, sz, cz);
    e[0] = q30_smul(cy, cz);
    e[1] = -q30_smul(cy, sz);
    e[2] = sy;
    e[3] = q30_smul(q30_smul(sx, sy), cz) + q30_smul(cx, sz);
    e[4] = q30_smul(cx, cz) - q30_smul(q30_smul(sx, sy), sz);
    e[5] = -q30_smul(sx, cy);
    e[6] = q30_smul(sx, sz) - q30_smul(q30_smul(cx, sy), cz);
    e[7] = q30_smul(q30_smul(cx, sy), sz) + q30_smul(sx, cz);
    e[8] = q30_smul(cx, cy);
    scl = '{w.sx, w.sy, w.sz};
    for (int i = 0; i < 9; i++) o.m[i] = scale_sat(e[i], scl[i % 3]);
    o.tx = w.px;
    o.ty = w.py;
    o.tz = w.pz;
  endtask

  function automatic logic [31:0] rand_field(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 1440)) - 720) << FB;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 4;
    endcase
  endfunction

  function automatic xform_in_t rand_word();
    xform_in_t w;
    w.px = rand_field($urandom_range(0, 3));
    w.py = rand_field($urandom_range(0, 3));
    w.pz = rand_field($urandom_range(0, 3));
    w.ax = rand_field($urandom_range(0, 4) == 0 ? 0 : 2 + $urandom_range(0, 1));
    w.ay = rand_field($urandom_range(0, 4) == 0 ? 0 : 2 + $urandom_range(0, 1));
    w.az = rand_field($urandom_range(0, 4) == 0 ? 0 : 2 + $urandom_range(0, 1));
    w.sx = rand_field($urandom_range(0, 3));
    w.sy = rand_field($urandom_range(0, 3));
    w.sz = rand_field($urandom_range(0, 3));
    return w;
  endfunction

  function automatic xform_in_t make_word(logic [31:0] p, logic [31:0] ax, logic [31:0] ay,
                                          logic [31:0] az, logic [31:0] s);
    xform_in_t w;
    w.px = p; w.py = ~p; w.pz = p ^ 32'h5555_5555;
    w.ax = ax; w.ay = ay; w.az = az;
    w.sx = s; w.sy = s; w.sz = s;
    return w;
  endfunction

  initial begin
    localparam logic [31:0] UNIT = 32'h0001_0000;
    logic [31:0] deg [0:7];
    deg = '{32'd0, 32'd90 << FB, 32'd180 << FB, 32'd270 << FB, 32'd360 << FB,
            -(32'd90 << FB), 32'd45 << FB, 32'd30 << FB};
    for (int i = 0; i < 8; i++)
      pending_words.push_back(make_word(32'h0000_0000, deg[i], deg[(i + 1) % 8],
                                        deg[(i + 3) % 8], UNIT));
    pending_words.push_back(make_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                      32'hffff_ffff, 32'h7fff_ffff));
    pending_words.push_back(make_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                      32'h0000_0001, 32'h8000_0000));
    pending_words.push_back(make_word(32'hffff_ffff, 32'd89 << FB, 32'd179 << FB,
                                      32'd359 << FB, 32'hffff_ffff));
    pending_words.push_back(make_word(32'h1234_5678, 32'h0059_ffff, 32'h005a_0001,
                                      32'h0168_0000, 32'h0000_0000));
    pending_words.push_back(make_word(32'hdead_beef, 32'd45 << FB, 32'd45 << FB,
                                      32'd45 << FB, 32'h4000_0000));
    pending_words.push_back(make_word(32'h0101_0101, 32'd3600 << FB, -(32'd3690 << FB),
                                      32'd1 << FB, 32'hc000_0000));
    for (int i = 0; i < 1100; i++) pending_words.push_back(rand_word());
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (start && !busy) begin
        matrix_out_t o;
        predict_matrix('{pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                         scale_x, scale_y, scale_z}, o);
        expected_matrices.push_back(o);
        issued <= issued + 1;
      end
      if (start && busy) begin
        // hold current word
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else if (issued >= 500 && !hold_for_drain) begin
        start <= 1'b0;
        hold_for_drain <= 1'b1;
        drain_at <= cycle;
      end else if (drain_at >= 0) begin
        start <= 1'b0;
        if (expected_matrices.size() == 0) drain_at <= -1;
      end else if ((issued > 200 && issued < 400) || $urandom_range(0, 99) >= 26) begin
        xform_in_t w;
        w = pending_words.pop_front();
        start <= 1'b1;
        pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
        angle_x <= w.ax; angle_y <= w.ay; angle_z <= w.az;
        scale_x <= w.sx; scale_y <= w.sy; scale_z <= w.sz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        logic [31:0] got [0:11];
        matrix_out_t e;
        got = '{r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                trans_x, trans_y, trans_z};
        if (expected_matrices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word at cycle %0d", cycle);
        end else begin
          e = expected_matrices.pop_front();
          for (int i = 0; i < 12; i++) begin
            logic [31:0] want;
            want = i < 9 ? e.m[i] : (i == 9 ? e.tx : (i == 10 ? e.ty : e.tz));
            if (got[i] !== want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("field %0d: expected %h got %h", i, want, got[i]);
            end
          end
        end
      end
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (!(stim_done && expected_matrices.size() == 0 && !start));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/trsmb_pkg.sv
rtl/trs_model_matrix_builder_core.sv
rtl/trsmb_checker.sv
bench/tb_top.sv
